FILE: hdl/pcapd_pkg.sv
// pcapd_pkg: shared types, constants and helpers for the pcap stream deframer.
// Used by pcapd_parser and pcap_stream_deframer_core; depends on nothing.
package pcapd_pkg;

	localparam int unsigned MAX_BODY_DEF = 65536;
	localparam int unsigned CAP_W        = 17;
	localparam logic [CAP_W-1:0] MAX_CAPTURE_RST = 17'h10000;

	localparam logic [31:0] MAGIC_NATIVE  = 32'ha1b2c3d4;
	localparam logic [31:0] MAGIC_SWAPPED = 32'hd4c3b2a1;

	// last byte index of each header
	localparam int unsigned STREAM_HDR_LAST = 23;
	localparam int unsigned REC_HDR_LAST    = 15;
	localparam int unsigned MAGIC_LAST      = 3;

	localparam int unsigned TDATA_W = 248;
	localparam int unsigned TUSER_W = 3;

	typedef enum logic [1:0] {
		PH_STREAM,
		PH_RECORD,
		PH_BODY,
		PH_DEAD
	} phase_t;

	typedef enum logic [2:0] {
		EV_STREAM_OK = 3'd0,
		EV_RECORD_OK = 3'd1,
		EV_BODY      = 3'd2,
		EV_BAD_MAGIC = 3'd3,
		EV_TOO_LONG  = 3'd4,
		EV_EMPTY     = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		HW_SECONDS,
		HW_MICROS,
		HW_CAPLEN,
		HW_WIRELEN
	} hdr_word_t;

	typedef struct packed {
		logic [47:0] byte_total;
		logic [31:0] packet_count;
		logic [31:0] link_layer;
		logic [31:0] wire_length;
		logic [31:0] capture_length;
		logic [31:0] ts_micros;
		logic [31:0] ts_seconds;
		logic [7:0]  data_byte;
		logic        last_byte;
		event_t      event_res;
	} pcapd_res_t;

	function automatic logic [31:0] flip32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

FILE: hdl/pcapd_parser.sv
// pcapd_parser: deframer state (phase, byte index, header words, counters) and
// the per-byte next-state / result logic. Depends on pcapd_pkg.
module pcapd_parser
	import pcapd_pkg::*;
#(
	parameter int unsigned MAX_BODY = MAX_BODY_DEF,
	parameter int unsigned IDX_W    = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       in_byte,
	input  logic [CAP_W-1:0] max_capture,
	output logic             res_valid,
	output pcapd_res_t       res
);

	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             swap_q, swap_d;
	logic             bad_q, bad_d;
	logic [31:0]      shift_q, shift_d;
	logic [31:0]      sec_q, sec_d;
	logic [31:0]      usec_q, usec_d;
	logic [31:0]      caplen_q, caplen_d;
	logic [31:0]      wirelen_q, wirelen_d;
	logic [31:0]      link_q, link_d;
	logic [31:0]      pkts_q, pkts_d;
	logic [47:0]      total_q, total_d;

	logic [31:0] ws;
	logic [31:0] fixed;
	event_t      ev;
	logic [7:0]  data_b;
	logic        last_b;

	assign ws    = {in_byte, shift_q[31:8]};
	assign fixed = swap_q ? flip32(ws) : ws;

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		swap_d    = swap_q;
		bad_d     = bad_q;
		shift_d   = shift_q;
		sec_d     = sec_q;
		usec_d    = usec_q;
		caplen_d  = caplen_q;
		wirelen_d = wirelen_q;
		link_d    = link_q;
		pkts_d    = pkts_q;
		total_d   = total_q;
		res_valid = 1'b0;
		ev        = EV_STREAM_OK;
		data_b    = 8'd0;
		last_b    = 1'b0;
		unique case (phase_q)
			PH_STREAM: begin
				shift_d = ws;
				if (idx_q == IDX_W'(MAGIC_LAST)) begin
					priority if (ws == MAGIC_NATIVE) begin
						swap_d = 1'b0;
						bad_d  = 1'b0;
					end else if (ws == MAGIC_SWAPPED) begin
						swap_d = 1'b1;
						bad_d  = 1'b0;
					end else begin
						bad_d = 1'b1;
					end
				end
				if (idx_q >= IDX_W'(STREAM_HDR_LAST)) begin
					idx_d     = '0;
					res_valid = 1'b1;
					if (bad_d) begin
						phase_d = PH_DEAD;
						ev      = EV_BAD_MAGIC;
					end else begin
						link_d  = fixed;
						phase_d = PH_RECORD;
						ev      = EV_STREAM_OK;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			PH_RECORD: begin
				shift_d = ws;
				if (idx_q[1:0] == 2'd3) begin
					unique case (hdr_word_t'(idx_q[3:2]))
						HW_SECONDS: sec_d     = fixed;
						HW_MICROS:  usec_d    = fixed;
						HW_CAPLEN:  caplen_d  = fixed;
						HW_WIRELEN: wirelen_d = fixed;
					endcase
				end
				if (idx_q >= IDX_W'(REC_HDR_LAST)) begin
					idx_d     = '0;
					res_valid = 1'b1;
					priority if (caplen_d > {{(32-CAP_W){1'b0}}, max_capture} ||
					             caplen_d > 32'(MAX_BODY)) begin
						phase_d = PH_DEAD;
						ev      = EV_TOO_LONG;
					end else if (caplen_d == 32'd0 || wirelen_d == 32'd0) begin
						phase_d = PH_DEAD;
						ev      = EV_EMPTY;
					end else begin
						phase_d = PH_BODY;
						ev      = EV_RECORD_OK;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			PH_BODY: begin
				res_valid = 1'b1;
				ev        = EV_BODY;
				data_b    = in_byte;
				if (32'(idx_q) + 32'd1 >= caplen_q) begin
					last_b  = 1'b1;
					pkts_d  = pkts_q + 32'd1;
					total_d = total_q + {16'd0, wirelen_q};
					idx_d   = '0;
					phase_d = PH_RECORD;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			PH_DEAD: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.event_res      = ev;
		res.data_byte      = data_b;
		res.last_byte      = last_b;
		res.ts_seconds     = sec_d;
		res.ts_micros      = usec_d;
		res.capture_length = caplen_d;
		res.wire_length    = wirelen_d;
		res.link_layer     = link_d;
		res.packet_count   = pkts_d;
		res.byte_total     = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STREAM;
			idx_q     <= '0;
			swap_q    <= 1'b0;
			bad_q     <= 1'b0;
			shift_q   <= '0;
			sec_q     <= '0;
			usec_q    <= '0;
			caplen_q  <= '0;
			wirelen_q <= '0;
			link_q    <= '0;
			pkts_q    <= '0;
			total_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			idx_q     <= idx_d;
			swap_q    <= swap_d;
			bad_q     <= bad_d;
			shift_q   <= shift_d;
			sec_q     <= sec_d;
			usec_q    <= usec_d;
			caplen_q  <= caplen_d;
			wirelen_q <= wirelen_d;
			link_q    <= link_d;
			pkts_q    <= pkts_d;
			total_q   <= total_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_dead_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DEAD |-> !res_valid)
		else $error("result produced after a fatal event");

	a_body_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> 32'(idx_q) < caplen_q)
		else $error("body index ran past captured length");

	a_fatal_dead: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && (ev == EV_BAD_MAGIC || ev == EV_TOO_LONG || ev == EV_EMPTY)
		|=> phase_q == PH_DEAD)
		else $error("fatal event did not stop the parser");

	a_count_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && !(res_valid && last_b) |=> $stable(pkts_q))
		else $error("packet count moved without a last body byte");
`endif

endmodule

FILE: hdl/pcap_stream_deframer_core.sv
// pcap_stream_deframer_core: top level of the pcap stream deframer.
// Instantiates pcapd_parser; types and constants from pcapd_pkg.
//
// Takes a pcap capture stream one byte per word on the slave stream and
// sustains one byte per clock while the result stream is not stalled. The
// 24-byte stream header is checked for a native or byte-swapped magic and
// its link type is kept; each 16-byte record header is decoded and checked
// against max_capture and MAX_BODY; body bytes come out one per word with
// tlast on the final byte of the record. A word comes out at the end of each
// header (status in tuser) and for every body byte; other header bytes
// produce nothing. Bad magic, an oversize record or a zero length is reported
// once and then the core swallows all input until reset. The input byte is
// registered, then decoded in one step into the output register. Throughput
// is one byte per cycle unless the result stream stalls; the output register
// and the input register together let an input byte be taken while a result
// still waits. max_capture is written through cfg_we/cfg_wdata; the user must
// write it only while the core is idle, the core does not enforce it.
module pcap_stream_deframer_core
	import pcapd_pkg::*;
#(
	parameter int unsigned MAX_BODY = MAX_BODY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input stream
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] in_byte
	// result stream
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [7:0] data_byte, [39:8] ts_seconds, [71:40] ts_micros,
	// [103:72] capture_length, [135:104] wire_length, [167:136] link_layer,
	// [199:168] packet_count, [247:200] byte_total
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tlast,   // last_byte
	output logic [TUSER_W-1:0] m_axis_tuser,   // [2:0] event_res
	// configuration
	input  logic               cfg_we,
	input  logic [CAP_W-1:0]   cfg_wdata       // max_capture
);

	// body index holds up to MAX_BODY-1, header index up to 23
	localparam int unsigned BODY_IDX_W = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
	localparam int unsigned IDX_W      = (BODY_IDX_W > 5) ? BODY_IDX_W : 5;

	logic [CAP_W-1:0] max_capture_q;

	// input stage
	logic       in_vld_s1;
	logic [7:0] in_byte_s1;

	// result register
	logic       out_vld_s2;
	pcapd_res_t out_s2;

	logic       advance;
	logic       step;
	logic       res_valid;
	pcapd_res_t res;

	// result register frees up when empty or drained this cycle
	assign advance       = !out_vld_s2 || m_axis_tready;
	assign step          = in_vld_s1 && advance;
	assign s_axis_tready = !in_vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_capture_q <= MAX_CAPTURE_RST;
		end else if (cfg_we) begin
			max_capture_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	pcapd_parser #(
		.MAX_BODY (MAX_BODY),
		.IDX_W    (IDX_W)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.in_byte     (in_byte_s1),
		.max_capture (max_capture_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s2 <= 1'b0;
		end else if (advance) begin
			out_vld_s2 <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_s2 <= res;
		end
	end

	assign m_axis_tvalid = out_vld_s2;
	assign m_axis_tlast  = out_s2.last_byte;
	assign m_axis_tuser  = out_s2.event_res;
	assign m_axis_tdata  = {out_s2.byte_total, out_s2.packet_count, out_s2.link_layer,
	                        out_s2.wire_length, out_s2.capture_length, out_s2.ts_micros,
	                        out_s2.ts_seconds, out_s2.data_byte};

`ifndef NO_ASSERTIONS
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_s2 && !m_axis_tready |=> out_vld_s2 && $stable(out_s2))
		else $error("stalled result word changed");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld_s1 && !advance |=> in_vld_s1 && $stable(in_byte_s1))
		else $error("held input byte lost");

	a_body_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_s2 && out_s2.event_res != EV_BODY |-> !out_s2.last_byte &&
		out_s2.data_byte == 8'd0)
		else $error("header event carries body payload");
`endif

endmodule

FILE: bench/tb_pcap_stream_deframer_core.sv
// tb_pcap_stream_deframer_core: self-checking bench for the pcap stream deframer.
// Feeds pcap byte streams, predicts every result word in place and checks it field by field.
// Depends on pcapd_pkg and pcap_stream_deframer_core.
module tb_pcap_stream_deframer_core;
	import pcapd_pkg::*;

	localparam int unsigned BODY_CAP   = MAX_BODY_DEF;
	localparam int unsigned IDLE_PCT   = 11;
	localparam int unsigned RAND_ITEMS = 600;
	localparam int unsigned STALL_MAX  = 1000;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic                m_axis_tlast;
	logic [TUSER_W-1:0]  m_axis_tuser;
	logic                cfg_we = 1'b0;
	logic [CAP_W-1:0]    cfg_wdata = '0;

	// stimulus side
	logic [7:0]  byte_q[$];
	bit          tx_swap;
	bit          calm;       // no idling on either side while set

	// predicted deframer state, starts at its reset values
	logic [CAP_W-1:0] cap_limit = MAX_CAPTURE_RST;
	phase_t      st_phase = PH_STREAM;
	logic [16:0] st_pos = '0;
	logic        st_swap = 1'b0;
	logic        st_badmagic = 1'b0;
	logic [31:0] st_window = '0;
	logic [31:0] rec_sec = '0;
	logic [31:0] rec_usec = '0;
	logic [31:0] rec_cap = '0;
	logic [31:0] rec_wire = '0;
	logic [31:0] kept_link = '0;
	logic [31:0] pkt_cnt = '0;
	logic [47:0] wire_sum = '0;

	pcapd_res_t  want_q[$];
	pcapd_res_t  head;
	int          faults;
	int          idle_run;

	pcap_stream_deframer_core #(
		.MAX_BODY(BODY_CAP)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] host_order(input logic [31:0] v);
		logic [31:0] r;
		r = {<<8{v}};
		return st_swap ? r : v;
	endfunction

	// one accepted stream byte: advance the predicted state, queue the word it causes
	task automatic deframe_byte(input logic [7:0] b);
		logic [31:0] win;
		pcapd_res_t  r;
		logic        fire;
		win = {b, st_window[31:8]};
		r = '0;
		fire = 1'b0;
		case (st_phase)
		PH_STREAM: begin
			st_window = win;
			if (st_pos == MAGIC_LAST) begin
				if (win == MAGIC_NATIVE) begin
					st_swap = 1'b0;
					st_badmagic = 1'b0;
				end else if (win == MAGIC_SWAPPED) begin
					st_swap = 1'b1;
					st_badmagic = 1'b0;
				end else
					st_badmagic = 1'b1;
			end
			if (st_pos >= STREAM_HDR_LAST) begin
				st_pos = '0;
				fire = 1'b1;
				if (st_badmagic) begin
					st_phase = PH_DEAD;
					r.event_res = EV_BAD_MAGIC;
				end else begin
					kept_link = host_order(win);
					st_phase = PH_RECORD;
					r.event_res = EV_STREAM_OK;
				end
			end else
				st_pos = st_pos + 1'b1;
		end
		PH_RECORD: begin
			st_window = win;
			if (st_pos[1:0] == 2'b11) begin
				case (hdr_word_t'(st_pos[3:2]))
				HW_SECONDS: rec_sec = host_order(win);
				HW_MICROS:  rec_usec = host_order(win);
				HW_CAPLEN:  rec_cap = host_order(win);
				default:    rec_wire = host_order(win);
				endcase
			end
			if (st_pos >= REC_HDR_LAST) begin
				st_pos = '0;
				fire = 1'b1;
				// length limit wins over the empty check
				if (rec_cap > 32'(cap_limit) || rec_cap > BODY_CAP) begin
					st_phase = PH_DEAD;
					r.event_res = EV_TOO_LONG;
				end else if (rec_cap == 0 || rec_wire == 0) begin
					st_phase = PH_DEAD;
					r.event_res = EV_EMPTY;
				end else begin
					st_phase = PH_BODY;
					r.event_res = EV_RECORD_OK;
				end
			end else
				st_pos = st_pos + 1'b1;
		end
		PH_BODY: begin
			fire = 1'b1;
			r.event_res = EV_BODY;
			r.data_byte = b;
			if (32'(st_pos) + 1 >= rec_cap) begin
				// record complete: counters move before the word is built
				pkt_cnt = pkt_cnt + 1;
				wire_sum = wire_sum + 48'(rec_wire);
				st_pos = '0;
				st_phase = PH_RECORD;
				r.last_byte = 1'b1;
			end else
				st_pos = st_pos + 1'b1;
		end
		default: ;  // dead until reset
		endcase
		if (fire) begin
			r.ts_seconds = rec_sec;
			r.ts_micros = rec_usec;
			r.capture_length = rec_cap;
			r.wire_length = rec_wire;
			r.link_layer = kept_link;
			r.packet_count = pkt_cnt;
			r.byte_total = wire_sum;
			want_q.push_back(r);
		end
	endtask

	task automatic cmp_field(input string what, input logic [47:0] want, input logic [47:0] got);
		if (want !== got) begin
			if (faults < 10)
				$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			faults++;
		end
	endtask

	// stream bytes in the order the capture was written
	task automatic put_word(input logic [31:0] v);
		for (int k = 0; k < 4; k++)
			byte_q.push_back(tx_swap ? v[31-8*k -: 8] : v[8*k +: 8]);
	endtask

	task automatic put_header(input logic [31:0] magic, input logic [31:0] link);
		put_word(magic);
		repeat (4) put_word($urandom);  // version, zone, sigfigs, snaplen
		put_word(link);
	endtask

	task automatic put_rec_head(input logic [31:0] sec, input logic [31:0] usec,
			input logic [31:0] cap, input logic [31:0] wlen);
		put_word(sec);
		put_word(usec);
		put_word(cap);
		put_word(wlen);
	endtask

	// fill < 0 gives a random body
	task automatic put_record(input logic [31:0] sec, input logic [31:0] usec,
			input logic [31:0] cap, input logic [31:0] wlen, input int fill);
		put_rec_head(sec, usec, cap, wlen);
		for (int unsigned k = 0; k < cap; k++)
			byte_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
	endtask

	function automatic int unsigned room();
		return (cap_limit < 24) ? int'(cap_limit) : 24;
	endfunction

	// wait until nothing is queued, in flight or expected, plus the pipeline depth
	task automatic settle();
		while (byte_q.size() != 0 || s_axis_tvalid || want_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_limit(input logic [CAP_W-1:0] v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_limit = v;
		@(negedge clk);
	endtask

	// source side: one word per handshake, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				deframe_byte(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= byte_q.pop_front();
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// sink side: random back-pressure, compare against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (want_q.size() == 0) begin
					if (faults < 10)
						$display("%0t: unexpected word, event %0d", $time, m_axis_tuser);
					faults++;
				end else begin
					head = want_q.pop_front();
					cmp_field("event_res", 48'(head.event_res), 48'(m_axis_tuser[2:0]));
					cmp_field("data_byte", 48'(head.data_byte), 48'(m_axis_tdata[7:0]));
					cmp_field("last_byte", 48'(head.last_byte), 48'(m_axis_tlast));
					cmp_field("ts_seconds", 48'(head.ts_seconds), 48'(m_axis_tdata[39:8]));
					cmp_field("ts_micros", 48'(head.ts_micros), 48'(m_axis_tdata[71:40]));
					cmp_field("capture_length", 48'(head.capture_length),
						48'(m_axis_tdata[103:72]));
					cmp_field("wire_length", 48'(head.wire_length), 48'(m_axis_tdata[135:104]));
					cmp_field("link_layer", 48'(head.link_layer), 48'(m_axis_tdata[167:136]));
					cmp_field("packet_count", 48'(head.packet_count), 48'(m_axis_tdata[199:168]));
					cmp_field("byte_total", head.byte_total, m_axis_tdata[247:200]);
				end
			end
			m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// watchdog: too long without a handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_run <= 0;
			else if (idle_run >= STALL_MAX) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else
				idle_run <= idle_run + 1;
		end
	end

	initial begin
		logic [31:0] cap;
		logic [31:0] wlen;
		logic [31:0] magic;
		int          recs;
		int          n_rand;
		int          kind;
		faults = 0;
		idle_run = 0;
		calm = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		tx_swap = 1'($urandom_range(0, 1));

		if ($urandom_range(0, 7) == 0) begin
			// bad magic: one bit off a good magic, then everything is swallowed
			set_limit(CAP_W'($urandom_range(1, 65536)));
			magic = ($urandom_range(0, 1) ? MAGIC_NATIVE : MAGIC_SWAPPED)
				^ (32'h1 << $urandom_range(0, 31));
			put_header(magic, $urandom);
			put_record($urandom, $urandom, 4, 60, -1);
			repeat (RAND_ITEMS + 160) byte_q.push_back(8'($urandom));
		end else begin
			// directed: tightest limit, field extremes, limit hit exactly, limit above MAX_BODY
			set_limit(17'd1);
			put_header(MAGIC_NATIVE, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom);
			put_record(32'h0, 32'h0, 1, 1, 8'h00);
			put_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 8'hFF);
			set_limit(17'd3);
			put_record($urandom, $urandom, 3, $urandom_range(1, 1500), -1);
			put_record($urandom, $urandom, 2, 1, -1);
			set_limit(17'h1FFFF);
			put_record($urandom, $urandom, $urandom_range(25, 64), $urandom_range(1, 1500), -1);
			set_limit(MAX_CAPTURE_RST);

			// random well-formed records, limit changed every eight records
			recs = 0;
			n_rand = 0;
			while (n_rand < RAND_ITEMS) begin
				if (recs % 8 == 0) begin
					set_limit(CAP_W'($urandom_range(0, 2) == 0 ? $urandom_range(1, 16)
						: $urandom_range(17, 131071)));
					calm = (recs == 8);
				end
				cap = ($urandom_range(0, 3) == 0) ? room() : $urandom_range(1, room());
				wlen = $urandom_range(0, 1) ? $urandom_range(1, 1500) : $urandom;
				if (wlen == 0)
					wlen = 1;
				put_record($urandom, $urandom, cap, wlen, -1);
				n_rand += 16 + cap;
				recs++;
			end
			settle();
			calm = 1'b0;

			// one fatal record to close the run, then noise that must vanish
			kind = $urandom_range(0, 3);
			case (kind)
			0: begin
				set_limit(CAP_W'($urandom_range(0, 1) ? 0 : $urandom_range(1, 16)));
				cap = 32'(cap_limit) + $urandom_range(1, 300);
				put_rec_head($urandom, $urandom, cap, $urandom_range(0, 3) == 0 ? 0 : $urandom);
			end
			1: begin
				set_limit(17'h1FFFF);
				cap = $urandom_range(0, 1) ? $urandom_range(BODY_CAP + 1, 131071)
					: ($urandom | 32'h8000_0000);
				put_rec_head($urandom, $urandom, cap, $urandom);
			end
			2: put_rec_head($urandom, $urandom, 0, $urandom_range(1, 1500));
			default: put_rec_head($urandom, $urandom, $urandom_range(1, room()), 0);
			endcase
			repeat (40) byte_q.push_back(8'($urandom));
		end

		settle();
		repeat (4) @(negedge clk);
		if (faults == 0 && want_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
hdl/pcapd_pkg.sv
hdl/pcapd_parser.sv
hdl/pcap_stream_deframer_core.sv
bench/tb_pcap_stream_deframer_core.sv
